FILE: src/device_threshold_alarm_tracker_top_defines.svh
// assertion macros for the alarm tracker
`ifndef DEVICE_THRESHOLD_ALARM_TRACKER_TOP_DEFINES_SVH
`define DEVICE_THRESHOLD_ALARM_TRACKER_TOP_DEFINES_SVH

// same-cycle implication
`define DTA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dta_pkg.sv
`default_nettype none

package dta_pkg;

  localparam int NUM_KINDS = 5;
  localparam int DEV_W     = 8;
  localparam int VAL_W     = 16;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 8;
  localparam int IN_DATA_W = 48;

  localparam int DEVICE_COUNT_DEF = 256;

  localparam logic signed [VAL_W-1:0] TEMP_HIGH_RST = 16'sd50;
  localparam logic signed [VAL_W-1:0] TEMP_LOW_RST  = 16'sd15;
  localparam logic [VAL_W-1:0]        VOLT_HIGH_RST = 16'd230;
  localparam logic [VAL_W-1:0]        VOLT_LOW_RST  = 16'd210;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_TEMP_HIGH = 3'd0;
  localparam kind_t KIND_TEMP_LOW  = 3'd1;
  localparam kind_t KIND_VOLT_HIGH = 3'd2;
  localparam kind_t KIND_VOLT_LOW  = 3'd3;
  localparam kind_t KIND_OFFLINE   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_HIGH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_LOW  = 8'd3;

  typedef logic [NUM_KINDS-1:0] flags_t;

endpackage

`default_nettype wire

FILE: src/device_threshold_alarm_tracker_top.sv
// channel  | ports                       | contents
// in       | in_tvalid/in_tready/in_tdata | one reading per item
// out      | out_tvalid/out_tready/...    | one alarm event per item, tlast on final one
// cfg      | cfg_valid/cfg_ready          | limit register writes, always ready
// an item is accepted, its stored flags are read from the flag store and compared in the eval state,
// then its events are loaded one at a time, each once the event register is free
// the next item is accepted once all events are loaded; the last may still wait on out_tready
// reset clears limits, control state and per-device valid bits; flag store needs no sweep
// a reading for a device beyond the store is dropped in its accept cycle
`default_nettype none
`include "device_threshold_alarm_tracker_top_defines.svh"

module device_threshold_alarm_tracker_top #(
  parameter int DEVICE_COUNT = dta_pkg::DEVICE_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [7:0] device_id, [23:8] temperature_reading, [39:24] voltage_reading, [40] is_online
  input  wire logic [dta_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [7:0] event_device
  output logic [dta_pkg::DEV_W-1:0]              out_tdata,
  // [2:0] alarm_kind, [3] recovered
  output logic [dta_pkg::KIND_W:0]               out_tuser,
  output logic                                   out_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dta_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dta_pkg::VAL_W-1:0]         cfg_data
);

  localparam int MEM_DEPTH = (DEVICE_COUNT < 256) ? DEVICE_COUNT : 256;
  localparam int IDX_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [16:0] DEV_LIMIT = 17'(DEVICE_COUNT);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_EMIT} state_t;

  state_t state_r, state_nxt;

  logic signed [dta_pkg::VAL_W-1:0] temp_high_r, temp_low_r;
  logic [dta_pkg::VAL_W-1:0]        volt_high_r, volt_low_r;

  logic [dta_pkg::DEV_W-1:0] dev_r, dev_nxt;
  dta_pkg::flags_t           cond_r, cond_nxt;
  dta_pkg::flags_t           pend_r, pend_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [dta_pkg::DEV_W-1:0] out_dev_r, out_dev_nxt;
  dta_pkg::kind_t            out_kind_r, out_kind_nxt;
  logic                      out_rec_r, out_rec_nxt;
  logic                      out_last_r, out_last_nxt;

  dta_pkg::flags_t flag_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_r;
  dta_pkg::flags_t rd_data_r;
  logic            rd_vld_r;

  logic [dta_pkg::DEV_W-1:0]        in_dev;
  logic signed [dta_pkg::VAL_W-1:0] in_temp;
  logic [dta_pkg::VAL_W-1:0]        in_volt;
  logic                             in_online;
  logic                             in_acc, in_range;
  logic [IDX_W-1:0]                 rd_addr, wr_addr;
  logic                             wr_en;
  dta_pkg::flags_t                  flags_cur, diff;
  logic                             can_load, load;
  dta_pkg::kind_t                   sel_kind;
  dta_pkg::flags_t                  sel_mask;

  assign in_dev    = in_tdata[7:0];
  assign in_temp   = $signed(in_tdata[23:8]);
  assign in_volt   = in_tdata[39:24];
  assign in_online = in_tdata[40];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_range  = ({9'd0, in_dev} < DEV_LIMIT);
  assign rd_addr   = in_dev[IDX_W-1:0];
  assign wr_addr   = dev_r[IDX_W-1:0];

  assign cfg_ready = 1'b1;

  assign flags_cur = rd_vld_r ? rd_data_r : '0;
  assign diff      = cond_r ^ flags_cur;
  assign wr_en     = (state_r == S_EVAL);

  assign can_load  = !out_valid_r || out_tready;
  assign load      = (state_r == S_EMIT) && can_load;

  always_comb begin
    sel_kind = dta_pkg::KIND_TEMP_HIGH;
    for (int k = dta_pkg::NUM_KINDS - 1; k >= 0; k--) begin
      if (pend_r[k]) begin
        sel_kind = dta_pkg::kind_t'(k);
      end
    end
    sel_mask = dta_pkg::flags_t'(1) << sel_kind;
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_high_r <= dta_pkg::TEMP_HIGH_RST;
      temp_low_r  <= dta_pkg::TEMP_LOW_RST;
      volt_high_r <= dta_pkg::VOLT_HIGH_RST;
      volt_low_r  <= dta_pkg::VOLT_LOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dta_pkg::REG_TEMP_HIGH: temp_high_r <= $signed(cfg_data);
        dta_pkg::REG_TEMP_LOW:  temp_low_r  <= $signed(cfg_data);
        dta_pkg::REG_VOLT_HIGH: volt_high_r <= cfg_data;
        dta_pkg::REG_VOLT_LOW:  volt_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // flag store, read at accept, written back in the eval cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      flag_mem[wr_addr] <= cond_r;
    end
    rd_data_r <= flag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    dev_nxt       = dev_r;
    cond_nxt      = cond_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_dev_nxt   = out_dev_r;
    out_kind_nxt  = out_kind_r;
    out_rec_nxt   = out_rec_r;
    out_last_nxt  = out_last_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_range) begin
          dev_nxt  = in_dev;
          cond_nxt = {!in_online,
                      in_volt < volt_low_r,
                      in_volt > volt_high_r,
                      in_temp < temp_low_r,
                      in_temp > temp_high_r};
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        pend_nxt  = diff;
        state_nxt = (diff == '0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (can_load) begin
          pend_nxt      = pend_r & ~sel_mask;
          out_valid_nxt = 1'b1;
          out_dev_nxt   = dev_r;
          out_kind_nxt  = sel_kind;
          out_rec_nxt   = !(|(cond_r & sel_mask));
          out_last_nxt  = ((pend_r & ~sel_mask) == '0);
          if ((pend_r & ~sel_mask) == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dev_r      <= dev_nxt;
    cond_r     <= cond_nxt;
    out_dev_r  <= out_dev_nxt;
    out_kind_r <= out_kind_nxt;
    out_rec_r  <= out_rec_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_dev_r;
  assign out_tuser  = {out_rec_r, out_kind_r};
  assign out_tlast  = out_last_r;

  `DTA_ASSERT_IMP(a_idle_no_pending, clk, rst_n, state_r == S_IDLE, pend_r == '0,
    "pending events left while idle")
  `DTA_ASSERT_NXT(a_eval_to_emit, clk, rst_n, (state_r == S_EVAL) && (diff != '0),
    state_r == S_EMIT, "changed flags did not start event output")
  `DTA_ASSERT_NXT(a_one_event_per_load, clk, rst_n, load,
    $countones(pend_r) == $countones($past(pend_r)) - 1, "load did not retire one event")
  `DTA_ASSERT_IMP(a_kind_range, clk, rst_n, out_tvalid,
    out_tuser[dta_pkg::KIND_W-1:0] <= dta_pkg::KIND_OFFLINE, "event kind out of range")

endmodule

`default_nettype wire
